@@ rtl/core/crt_pkg.sv @@
// Package: types, register indexes and constants of the charge request and termination core.
`default_nettype none
package crt_pkg;

  localparam int unsigned NumEndTests = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgEndCurrent = 3'd0,
    CfgCellVoltLimit = 3'd1,
    CfgTaperVolt = 3'd2,
    CfgTempHigh = 3'd3,
    CfgTempLow = 3'd4
  } crt_cfg_idx_e;

  localparam logic [15:0] EndCurrentRst = 16'd30;
  localparam logic [15:0] CellVoltRst = 16'd36500;
  localparam logic [15:0] TaperVoltRst = 16'd36300;
  localparam logic [7:0] TempHighRst = 8'd95;
  localparam logic [7:0] TempLowRst = 8'd40;

  localparam logic [13:0] SocFullLevel = 14'd9980;
  localparam logic [2:0] MsgTimeoutCount = 3'd5;
  localparam logic [1:0] TaperHoldLast = 2'd3;
  localparam logic [1:0] AlarmLevel = 2'd2;

  // expiry thresholds: soc, low current, overvoltage, temp high, temp low
  localparam logic [2:0] DebLimit [NumEndTests] = '{3'd5, 3'd5, 3'd3, 3'd3, 3'd3};

  // floor(7 * x / 10) as floor(x * TaperMul / 2^TaperShift), exact for 16-bit x
  localparam int unsigned TaperShift = 22;
  localparam logic [21:0] TaperMul = 22'd2936017;

  typedef struct packed {
    logic [13:0] state_of_charge;
    logic signed [15:0] pack_current;
    logic [15:0] peak_cell_volt;
    logic [7:0] peak_cell_temp;
    logic [7:0] lowest_cell_temp;
    logic switch_off_fault;
    logic charger_fault;
    logic [15:0] charge_current_limit;
    logic [7:0] fault_levels;
    logic message_received;
  } crt_in_t;

  typedef struct packed {
    logic [15:0] current_request;
    logic stop_charge;
    logic temp_high_alarm;
    logic temp_low_alarm;
    logic overcurrent_alarm;
    logic insulation_alarm;
    logic message_timeout;
    logic any_fault;
  } crt_out_t;

endpackage
`default_nettype wire

@@ rtl/core/crt_if.sv @@
// Interfaces: input, result and configuration channels.
`default_nettype none
interface crt_in_if;
  import crt_pkg::*;
  logic valid;
  logic ready;
  crt_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface crt_out_if;
  import crt_pkg::*;
  logic valid;
  logic ready;
  crt_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface crt_cfg_if;
  import crt_pkg::*;
  logic valid;
  logic ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/charge_request_and_termination_core.sv @@
// Charge request and termination core: per-tick current request, end tests and flags.
//
// One input transaction per control tick on in_i gives exactly one result
// transaction on res_o. Registers are written through cfg_i (index 0..4),
// which is always ready; writes are meant for when no transaction is in flight.
// The input register takes the accepted transaction; request, debounce and flag
// logic then feed the result register, which drives res_o.
// Throughput: one transaction per cycle while res_o.ready holds; request and
// debounce state is updated as each transaction moves from the input register
// to the result register, so consecutive ticks see each other's state in order.
// When the receiver stalls, the result is held and the input register still
// takes one more transaction; in_i.ready drops only when both are full.
// Reset clears the request, debounce counts, taper and message state and
// loads the register defaults; no result is pending after reset.
`default_nettype none
module charge_request_and_termination_core
  import crt_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  crt_in_if.sink in_i,
  crt_out_if.source res_o,
  crt_cfg_if.sink cfg_i
);

  logic [15:0] end_cur_q, cell_volt_q, taper_volt_q;
  logic [7:0] temp_high_q, temp_low_q;

  logic in_valid_q, out_valid_q;
  crt_in_t in_q;
  crt_out_t out_q, out_d;
  logic advance;

  logic [15:0] last_req_q, last_req_d;
  logic [2:0] deb_q [NumEndTests];
  logic [2:0] deb_d [NumEndTests];
  logic armed_off_q, armed_off_d;
  logic [1:0] hold_q, hold_d;
  logic [2:0] msg_cnt_q, msg_cnt_d;

  logic [15:0] base;
  logic [37:0] taper_prod;
  logic [NumEndTests-1:0] cond;
  logic [2:0] inc;
  logic expired;
  logic faults;

  assign cfg_i.ready = 1'b1;
  assign advance = in_valid_q && (!out_valid_q || res_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign res_o.valid = out_valid_q;
  assign res_o.data = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_cur_q <= EndCurrentRst;
      cell_volt_q <= CellVoltRst;
      taper_volt_q <= TaperVoltRst;
      temp_high_q <= TempHighRst;
      temp_low_q <= TempLowRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgEndCurrent: end_cur_q <= cfg_i.data;
        CfgCellVoltLimit: cell_volt_q <= cfg_i.data;
        CfgTaperVolt: taper_volt_q <= cfg_i.data;
        CfgTempHigh: temp_high_q <= cfg_i.data[7:0];
        CfgTempLow: temp_low_q <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    base = (last_req_q <= end_cur_q) ? in_q.charge_current_limit : last_req_q;
    if (base > in_q.charge_current_limit) begin
      base = in_q.charge_current_limit;
    end
    taper_prod = 38'(base) * 38'(TaperMul);
    armed_off_d = armed_off_q;
    hold_d = hold_q;
    if ((in_q.peak_cell_volt >= taper_volt_q) && !armed_off_q) begin
      armed_off_d = 1'b1;
      last_req_d = taper_prod[TaperShift +: 16];
    end else begin
      if (hold_q >= TaperHoldLast) begin
        hold_d = '0;
        armed_off_d = 1'b0;
      end else begin
        hold_d = hold_q + 2'd1;
      end
      last_req_d = base;
    end
  end

  always_comb begin
    cond[0] = in_q.state_of_charge >= SocFullLevel;
    cond[1] = 17'(signed'(in_q.pack_current)) < signed'({1'b0, end_cur_q});
    cond[2] = in_q.peak_cell_volt > cell_volt_q;
    cond[3] = in_q.peak_cell_temp > temp_high_q;
    cond[4] = in_q.lowest_cell_temp < temp_low_q;
    expired = 1'b0;
    inc = '0;
    for (int i = 0; i < NumEndTests; i++) begin
      deb_d[i] = deb_q[i];
      if (!expired) begin
        inc = deb_q[i] + 3'd1;
        if (!cond[i]) begin
          deb_d[i] = '0;
        end else if (inc > DebLimit[i]) begin
          deb_d[i] = '0;
          expired = 1'b1;
        end else begin
          deb_d[i] = inc;
        end
      end
    end
  end

  always_comb begin
    faults = in_q.switch_off_fault || in_q.charger_fault;
    if (!in_q.message_received) begin
      msg_cnt_d = '0;
    end else if (msg_cnt_q < MsgTimeoutCount) begin
      msg_cnt_d = msg_cnt_q + 3'd1;
    end else begin
      msg_cnt_d = msg_cnt_q;
    end
    out_d.current_request = last_req_d;
    out_d.stop_charge = expired || faults;
    out_d.temp_high_alarm = in_q.fault_levels[1:0] == AlarmLevel;
    out_d.temp_low_alarm = in_q.fault_levels[3:2] == AlarmLevel;
    out_d.overcurrent_alarm = in_q.fault_levels[5:4] == AlarmLevel;
    out_d.insulation_alarm = in_q.fault_levels[7:6] == AlarmLevel;
    out_d.message_timeout = msg_cnt_d >= MsgTimeoutCount;
    out_d.any_fault = faults;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      last_req_q <= '0;
      armed_off_q <= 1'b0;
      hold_q <= '0;
      msg_cnt_q <= '0;
      for (int i = 0; i < NumEndTests; i++) begin
        deb_q[i] <= '0;
      end
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        last_req_q <= last_req_d;
        armed_off_q <= armed_off_d;
        hold_q <= hold_d;
        msg_cnt_q <= msg_cnt_d;
        for (int i = 0; i < NumEndTests; i++) begin
          deb_q[i] <= deb_d[i];
        end
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

endmodule
`default_nettype wire
